### rtl/orot_pkg.sv
// orot_pkg: shared widths for the oriented rectangle overlap test.
// No dependencies.
`default_nettype none
package orot_pkg;
   localparam int COORD_BITS_DEF    = 24;
   localparam int ROT_FRAC_BITS_DEF = 14;

   typedef struct packed {
      logic valid;
      logic aligned;
   } stage_ctl_type;
endpackage
`default_nettype wire

### rtl/orot_corner.sv
// orot_corner: stage 1, per-rectangle corner generation.
// Depends on orot_pkg.
`default_nettype none
module orot_corner #(
   parameter int CB = orot_pkg::COORD_BITS_DEF,
   parameter int RF = orot_pkg::ROT_FRAC_BITS_DEF,
   localparam int RB = RF + 2,
   localparam int PW = CB + RF + 4
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic signed [CB-1:0] cx,
   input  wire logic signed [CB-1:0] cy,
   input  wire logic [CB-2:0]        wd,
   input  wire logic [CB-2:0]        ht,
   input  wire logic signed [RB-1:0] rc,
   input  wire logic signed [RB-1:0] rs,
   output logic signed [PW-1:0]      px_ff [4],
   output logic signed [PW-1:0]      py_ff [4]
);
   import orot_pkg::*;

   logic signed [PW-1:0] bx, by, cw, sw, ch, sh;

   always_comb begin
      bx = PW'(cx) <<< (RF + 1);
      by = PW'(cy) <<< (RF + 1);
      cw = PW'(rc) * PW'($signed({1'b0, wd}));
      sw = PW'(rs) * PW'($signed({1'b0, wd}));
      ch = PW'(rc) * PW'($signed({1'b0, ht}));
      sh = PW'(rs) * PW'($signed({1'b0, ht}));
   end

   // corner k: ex = +-w by bit 0, ey = +-h by bit 1
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= bx + (k[0] ? cw : -cw) - (k[1] ? sh : -sh);
            py_ff[k] <= by + (k[1] ? ch : -ch) + (k[0] ? sw : -sw);
         end
      end
   end
endmodule
`default_nettype wire

### rtl/orot_axis.sv
// orot_axis: projection of eight corners on one axis, min/max, interval check.
// Stages: products, then min/max, then compare. Depends on orot_pkg.
`default_nettype none
module orot_axis #(
   parameter int CB = orot_pkg::COORD_BITS_DEF,
   parameter int RF = orot_pkg::ROT_FRAC_BITS_DEF,
   localparam int RB = RF + 2,
   localparam int PW = CB + RF + 4,
   localparam int DW = PW + RB + 2
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic signed [PW-1:0] px [8],
   input  wire logic signed [PW-1:0] py [8],
   input  wire logic signed [RB:0]   ax,
   input  wire logic signed [RB:0]   ay,
   output logic                      meet_ff
);
   import orot_pkg::*;

   logic signed [DW-1:0] d_ff [8];
   logic signed [DW-1:0] lo_ff [2];
   logic signed [DW-1:0] hi_ff [2];
   logic signed [DW-1:0] lo_in [2];
   logic signed [DW-1:0] hi_in [2];

   always_comb begin
      for (int g = 0; g < 2; g++) begin
         lo_in[g] = d_ff[4*g];
         hi_in[g] = d_ff[4*g];
         for (int i = 1; i < 4; i++) begin
            if (d_ff[4*g+i] < lo_in[g]) lo_in[g] = d_ff[4*g+i];
            if (d_ff[4*g+i] > hi_in[g]) hi_in[g] = d_ff[4*g+i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 8; i++) begin
            d_ff[i] <= DW'(px[i]) * DW'(ax) + DW'(py[i]) * DW'(ay);
         end
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         meet_ff <= !((hi_ff[0] < lo_ff[1]) || (hi_ff[1] < lo_ff[0]));
      end
   end
endmodule
`default_nettype wire

### rtl/oriented_rect_overlap_test_core.sv
// oriented_rect_overlap_test_core: top level of the 2D separating axis test.
// Depends on orot_pkg, orot_corner, orot_axis.
//
//   channel | ports                         | direction
//   request | req_valid, req_stall, fields  | in
//   result  | rsp_valid, rsp_stall, rsp_overlapping | out
//
// One request per cycle unless a held result is stalled; the stages are corners, products,
// min/max, interval compare, combine. The pipeline has no feedback.
// Reset clears only the valid bits. A stall on the result side freezes the
// whole pipeline; req_stall follows rsp_stall whenever the last stage holds.
`default_nettype none
module oriented_rect_overlap_test_core #(
   parameter int COORD_BITS    = orot_pkg::COORD_BITS_DEF,
   parameter int ROT_FRAC_BITS = orot_pkg::ROT_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_BITS-1:0]  req_center_x_a,
   input  wire logic signed [COORD_BITS-1:0]  req_center_y_a,
   input  wire logic [COORD_BITS-2:0]         req_width_a,
   input  wire logic [COORD_BITS-2:0]         req_height_a,
   input  wire logic signed [ROT_FRAC_BITS+1:0] req_cos_a,
   input  wire logic signed [ROT_FRAC_BITS+1:0] req_sin_a,
   input  wire logic signed [COORD_BITS-1:0]  req_center_x_b,
   input  wire logic signed [COORD_BITS-1:0]  req_center_y_b,
   input  wire logic [COORD_BITS-2:0]         req_width_b,
   input  wire logic [COORD_BITS-2:0]         req_height_b,
   input  wire logic signed [ROT_FRAC_BITS+1:0] req_cos_b,
   input  wire logic signed [ROT_FRAC_BITS+1:0] req_sin_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_overlapping
);
   import orot_pkg::*;

   localparam int RB = ROT_FRAC_BITS + 2;
   localparam int PW = COORD_BITS + ROT_FRAC_BITS + 4;
   localparam int CW = COORD_BITS + 2;
   localparam int NS = 5;

   logic enable;
   stage_ctl_type ctl_ff [NS];
   logic signed [PW-1:0] pa_x [4], pa_y [4], pb_x [4], pb_y [4];
   logic signed [PW-1:0] px [8], py [8];
   logic signed [RB:0] ax_ff [4], ay_ff [4];
   logic [3:0] meet;
   logic aa_ff [NS-1];
   logic aa_in;
   logic signed [CW-1:0] ax0, ax1, ay0, ay1, hw0, hw1, hh0, hh1;

   // advance unless a finished result is held
   assign enable    = !(ctl_ff[NS-1].valid && rsp_stall);
   assign req_stall = !enable;

   // axis-aligned test in units of 2^-1, decided at the input
   always_comb begin
      ax0 = CW'(req_center_x_a) <<< 1;
      ax1 = CW'(req_center_x_b) <<< 1;
      ay0 = CW'(req_center_y_a) <<< 1;
      ay1 = CW'(req_center_y_b) <<< 1;
      hw0 = CW'({1'b0, req_width_a});
      hw1 = CW'({1'b0, req_width_b});
      hh0 = CW'({1'b0, req_height_a});
      hh1 = CW'({1'b0, req_height_b});
      aa_in = !((ax0 + hw0 < ax1 - hw1) || (ax0 - hw0 > ax1 + hw1) ||
                (ay0 + hh0 < ay1 - hh1) || (ay0 - hh0 > ay1 + hh1));
   end

   // valid bits and the aligned-path select travel together
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) ctl_ff[s].valid <= 1'b0;
      end else if (enable) begin
         ctl_ff[0].valid <= req_valid;
         for (int s = 1; s < NS; s++) ctl_ff[s].valid <= ctl_ff[s-1].valid;
         ctl_ff[0].aligned <= (req_sin_a == '0) && (req_sin_b == '0);
         for (int s = 1; s < NS; s++) ctl_ff[s].aligned <= ctl_ff[s-1].aligned;
      end
   end

   // hold the axes and the aligned-path answer alongside the corners
   always_ff @(posedge clock) begin
      if (enable) begin
         aa_ff[0] <= aa_in;
         for (int s = 1; s < NS-1; s++) aa_ff[s] <= aa_ff[s-1];
         ax_ff[0] <= (RB+1)'(req_cos_a);
         ay_ff[0] <= (RB+1)'(req_sin_a);
         ax_ff[1] <= -(RB+1)'(req_sin_a);
         ay_ff[1] <= (RB+1)'(req_cos_a);
         ax_ff[2] <= (RB+1)'(req_cos_b);
         ay_ff[2] <= (RB+1)'(req_sin_b);
         ax_ff[3] <= -(RB+1)'(req_sin_b);
         ay_ff[3] <= (RB+1)'(req_cos_b);
         rsp_overlapping <= ctl_ff[NS-2].aligned ? aa_ff[NS-2] : (&meet);
      end
   end

   orot_corner #(.CB(COORD_BITS), .RF(ROT_FRAC_BITS)) u_corner_a (
      .clock, .enable, .cx(req_center_x_a), .cy(req_center_y_a),
      .wd(req_width_a), .ht(req_height_a), .rc(req_cos_a), .rs(req_sin_a),
      .px_ff(pa_x), .py_ff(pa_y));

   orot_corner #(.CB(COORD_BITS), .RF(ROT_FRAC_BITS)) u_corner_b (
      .clock, .enable, .cx(req_center_x_b), .cy(req_center_y_b),
      .wd(req_width_b), .ht(req_height_b), .rc(req_cos_b), .rs(req_sin_b),
      .px_ff(pb_x), .py_ff(pb_y));

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px[k] = pa_x[k]; py[k] = pa_y[k];
         px[k+4] = pb_x[k]; py[k+4] = pb_y[k];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_axis
      orot_axis #(.CB(COORD_BITS), .RF(ROT_FRAC_BITS)) u_axis (
         .clock, .enable, .px, .py, .ax(ax_ff[g]), .ay(ay_ff[g]),
         .meet_ff(meet[g]));
   end

   assign rsp_valid = ctl_ff[NS-1].valid;

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("held result lost");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_overlapping))
      else $error("held result changed");
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall mismatch");
endmodule
`default_nettype wire
